// ===== sv/bcqc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bcqc_pkg;

   // request kinds
   localparam logic [1:0] REQ_CHAR = 2'd0;
   localparam logic [1:0] REQ_EOL  = 2'd1;
   localparam logic [1:0] REQ_EOT  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_BALANCED = 2'd0;
   localparam logic [1:0] ST_UNEXP    = 2'd1;
   localparam logic [1:0] ST_UNCLOSED = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   // symbol kinds
   localparam int KIND_W = 3;
   localparam logic [2:0] K_ROUND   = 3'd0;
   localparam logic [2:0] K_SQUARE  = 3'd1;
   localparam logic [2:0] K_CURLY   = 3'd2;
   localparam logic [2:0] K_ANGLE   = 3'd3;
   localparam logic [2:0] K_COMMENT = 3'd4;
   localparam logic [2:0] K_SQUOTE  = 3'd5;
   localparam logic [2:0] K_DQUOTE  = 3'd6;

   // character codes
   localparam logic [7:0] CH_BSLASH = 8'd92;
   localparam logic [7:0] CH_SQUOTE = 8'd39;
   localparam logic [7:0] CH_DQUOTE = 8'd34;
   localparam logic [7:0] CH_SLASH  = 8'd47;
   localparam logic [7:0] CH_STAR   = 8'd42;
   localparam logic [7:0] CH_LROUND = 8'd40;
   localparam logic [7:0] CH_RROUND = 8'd41;
   localparam logic [7:0] CH_LSQ    = 8'd91;
   localparam logic [7:0] CH_RSQ    = 8'd93;
   localparam logic [7:0] CH_LCURLY = 8'd123;
   localparam logic [7:0] CH_RCURLY = 8'd125;
   localparam logic [7:0] CH_LANGLE = 8'd60;
   localparam logic [7:0] CH_RANGLE = 8'd62;

   // reported position widths
   localparam int ROW_OUT_W = 16;
   localparam int COL_OUT_W = 12;

   typedef logic [1:0]           req_kind_type;
   typedef logic [1:0]           status_type;
   typedef logic [KIND_W-1:0]    kind_type;
   typedef logic [ROW_OUT_W-1:0] row_out_type;
   typedef logic [COL_OUT_W-1:0] col_out_type;

   // stack operation requested in a cycle
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } stk_cmd_type;

endpackage

`default_nettype wire

// ===== sv/bcqc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// request channel: one source text word per handshake
interface bcqc_req_if;
   logic                  valid;
   logic                  ready;
   bcqc_pkg::req_kind_type req_type;
   logic [7:0]            ch;
   logic                  line_has_cout;
   logic                  line_has_cin;

   modport source (output valid, output req_type, output ch, output line_has_cout,
                   output line_has_cin, input ready);
   modport sink   (input valid, input req_type, input ch, input line_has_cout,
                   input line_has_cin, output ready);
endinterface

// response channel: one report word per handshake
interface bcqc_rsp_if;
   logic                  valid;
   logic                  ready;
   bcqc_pkg::status_type  status;
   bcqc_pkg::kind_type    symbol_kind;
   bcqc_pkg::row_out_type row_number;
   bcqc_pkg::col_out_type column_number;

   modport source (output valid, output status, output symbol_kind, output row_number,
                   output column_number, input ready);
   modport sink   (input valid, input status, input symbol_kind, input row_number,
                   input column_number, output ready);
endinterface

`default_nettype wire

// ===== sv/bcqc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcqc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/bcqc_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcqc_stack #(
   parameter int STACK_DEPTH = 64,
   parameter int ENTRY_W     = 31
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bcqc_pkg::stk_cmd_type          cmd,
   input  wire logic [ENTRY_W-1:0]             push_entry,
   output logic      [ENTRY_W-1:0]             top_entry,
   output logic      [$clog2(STACK_DEPTH+1)-1:0] depth
);

   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [DW-1:0]      depth_ff, depth_in;
   logic [ENTRY_W-1:0] top_ff, top_in;
   logic [ENTRY_W-1:0] fwd_ff;
   logic               fwd_sel_ff, fwd_sel_in;
   logic [ENTRY_W-1:0] rd_data;
   logic [ENTRY_W-1:0] second;
   logic [DW-1:0]      wr_sub, rd_sub;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic               wr_en;

   // entry below the top: from memory, or the word written last cycle
   assign second = fwd_sel_ff ? fwd_ff : rd_data;

   // top lives in a register, the rest of the stack in memory
   always_comb begin
      depth_in = depth_ff;
      top_in   = top_ff;
      wr_en    = 1'b0;
      if (cmd.clear) begin
         depth_in = '0;
      end else if (cmd.push) begin
         depth_in = depth_ff + DW'(1);
         top_in   = push_entry;
         wr_en    = (depth_ff != '0);
      end else if (cmd.pop) begin
         depth_in = depth_ff - DW'(1);
         top_in   = second;
      end
   end

   assign wr_sub  = depth_ff - DW'(1);
   assign wr_addr = wr_sub[AW-1:0];
   assign rd_sub  = depth_in - DW'(2);
   assign rd_addr = rd_sub[AW-1:0];

   // read and write to the same entry in the same cycle: bypass the memory
   assign fwd_sel_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= '0;
         fwd_sel_ff <= 1'b0;
      end else begin
         depth_ff   <= depth_in;
         fwd_sel_ff <= fwd_sel_in;
      end
      top_ff <= top_in;
      fwd_ff <= top_ff;
   end

   bcqc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (top_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign top_entry = top_ff;
   assign depth     = depth_ff;

endmodule

`default_nettype wire

// ===== sv/bracket_comment_quote_checker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bracket, comment and quote balance checker.
// req_chan carries one word per source event: a character, an end of line or
// an end of text, plus the caller's cout/cin flags for the current line.
// rsp_chan carries at most one report per request: unexpected closer, stack
// overflow (both stop checking until end of text), or at end of text either
// the innermost unclosed opener or balanced.
// Throughput is one request per cycle while no report is held but not taken. A
// report is registered and appears on rsp_chan in the cycle after its request
// is taken. The top of stack sits in a register and the entries below it in a
// one-port-write, registered-read RAM; the entry under the top is prefetched
// every cycle, so a pop the cycle after a push or pop needs no wait.
// req_chan.ready is low while reset is high and while a report is held but
// not taken; the report register holds its word until rsp_chan.ready.
// Synchronous reset clears the stack depth, position counters and line state;
// stack RAM contents are not cleared. End of text returns the stack depth,
// position counters and line state to their reset values.

module bracket_comment_quote_checker_top #(
   parameter int STACK_DEPTH = 64,
   parameter int ROW_BITS    = 16,
   parameter int COL_BITS    = 12
) (
   input wire logic   clock,
   input wire logic   reset,
   bcqc_req_if.sink   req_chan,
   bcqc_rsp_if.source rsp_chan
);

   localparam int DW      = $clog2(STACK_DEPTH + 1);
   localparam int ENTRY_W = bcqc_pkg::KIND_W + ROW_BITS + COL_BITS;

   typedef logic [ROW_BITS-1:0] row_type;
   typedef logic [COL_BITS-1:0] col_type;

   // line and position state
   row_type    row_ff, row_in;
   col_type    col_ff, col_in;
   logic [7:0] prev_ch_ff, prev_ch_in;
   logic       prev_vld_ff, prev_vld_in;
   logic       bs_par_ff, bs_par_in;
   logic       line_cmt_ff, line_cmt_in;
   logic       halted_ff, halted_in;

   // report register
   logic                  rsp_vld_ff;
   bcqc_pkg::status_type  rsp_status_ff;
   bcqc_pkg::kind_type    rsp_kind_ff;
   bcqc_pkg::row_out_type rsp_row_ff;
   bcqc_pkg::col_out_type rsp_col_ff;

   logic                  acc;
   bcqc_pkg::stk_cmd_type cmd;
   bcqc_pkg::kind_type    op_kind;
   logic [ENTRY_W-1:0]    push_entry;
   logic [ENTRY_W-1:0]    top_entry;
   logic [DW-1:0]         depth;
   bcqc_pkg::kind_type    top_kind;
   row_type               top_row;
   col_type               top_col;
   logic                  have_top, top_round, full;
   logic                  p_star, p_slash;

   logic                  res_vld;
   bcqc_pkg::status_type  res_status;
   bcqc_pkg::kind_type    res_kind;
   row_type               res_row;
   col_type               res_col;
   bcqc_pkg::row_out_type sat_row;
   bcqc_pkg::col_out_type sat_col;

   assign acc            = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !reset && (!rsp_vld_ff || rsp_chan.ready);

   assign top_kind  = top_entry[ENTRY_W-1 -: bcqc_pkg::KIND_W];
   assign top_row   = top_entry[ROW_BITS+COL_BITS-1:COL_BITS];
   assign top_col   = top_entry[COL_BITS-1:0];
   assign have_top  = (depth != '0);
   assign top_round = have_top && (top_kind == bcqc_pkg::K_ROUND);
   assign full      = (depth == DW'(STACK_DEPTH));
   assign p_star    = prev_vld_ff && (prev_ch_ff == bcqc_pkg::CH_STAR);
   assign p_slash   = prev_vld_ff && (prev_ch_ff == bcqc_pkg::CH_SLASH);

   // per-request decision
   always_comb begin
      logic       push_req;
      logic       pop_req;
      logic [7:0] c;

      push_req    = 1'b0;
      pop_req     = 1'b0;
      op_kind     = bcqc_pkg::K_ROUND;
      c           = req_chan.ch;
      cmd         = '0;
      res_vld     = 1'b0;
      res_status  = bcqc_pkg::ST_BALANCED;
      res_kind    = bcqc_pkg::K_ROUND;
      res_row     = row_ff;
      res_col     = col_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      prev_ch_in  = prev_ch_ff;
      prev_vld_in = prev_vld_ff;
      bs_par_in   = bs_par_ff;
      line_cmt_in = line_cmt_ff;
      halted_in   = halted_ff;

      if (acc) begin
         unique case (req_chan.req_type)
            bcqc_pkg::REQ_CHAR: begin
               if (!halted_ff && !line_cmt_ff) begin
                  if (have_top && top_kind == bcqc_pkg::K_COMMENT) begin
                     // inside a block comment only the closing pair counts
                     cmd.pop = (c == bcqc_pkg::CH_SLASH) && p_star;
                  end else if (have_top && (top_kind == bcqc_pkg::K_SQUOTE ||
                                            top_kind == bcqc_pkg::K_DQUOTE)) begin
                     // inside a quote only an unescaped matching quote counts
                     cmd.pop = !bs_par_ff &&
                               (c == ((top_kind == bcqc_pkg::K_SQUOTE) ?
                                      bcqc_pkg::CH_SQUOTE : bcqc_pkg::CH_DQUOTE));
                  end else if (c == bcqc_pkg::CH_SLASH && prev_vld_ff) begin
                     if (p_slash) begin
                        line_cmt_in = 1'b1;
                     end else if (p_star) begin
                        res_vld    = 1'b1;
                        res_status = bcqc_pkg::ST_UNEXP;
                        res_kind   = bcqc_pkg::K_COMMENT;
                        halted_in  = 1'b1;
                     end
                  end else if (c == bcqc_pkg::CH_STAR && prev_vld_ff) begin
                     push_req = p_slash;
                     op_kind  = bcqc_pkg::K_COMMENT;
                  end else begin
                     unique case (c)
                        bcqc_pkg::CH_SQUOTE: begin
                           push_req = 1'b1;
                           op_kind  = bcqc_pkg::K_SQUOTE;
                        end
                        bcqc_pkg::CH_DQUOTE: begin
                           push_req = 1'b1;
                           op_kind  = bcqc_pkg::K_DQUOTE;
                        end
                        bcqc_pkg::CH_LROUND: begin
                           push_req = 1'b1;
                           op_kind  = bcqc_pkg::K_ROUND;
                        end
                        bcqc_pkg::CH_LSQ: begin
                           push_req = 1'b1;
                           op_kind  = bcqc_pkg::K_SQUARE;
                        end
                        bcqc_pkg::CH_LCURLY: begin
                           push_req = 1'b1;
                           op_kind  = bcqc_pkg::K_CURLY;
                        end
                        bcqc_pkg::CH_LANGLE: begin
                           push_req = !top_round && !req_chan.line_has_cout;
                           op_kind  = bcqc_pkg::K_ANGLE;
                        end
                        bcqc_pkg::CH_RROUND: begin
                           pop_req = 1'b1;
                           op_kind = bcqc_pkg::K_ROUND;
                        end
                        bcqc_pkg::CH_RSQ: begin
                           pop_req = 1'b1;
                           op_kind = bcqc_pkg::K_SQUARE;
                        end
                        bcqc_pkg::CH_RCURLY: begin
                           pop_req = 1'b1;
                           op_kind = bcqc_pkg::K_CURLY;
                        end
                        bcqc_pkg::CH_RANGLE: begin
                           pop_req = !top_round && !req_chan.line_has_cin;
                           op_kind = bcqc_pkg::K_ANGLE;
                        end
                        default: ;
                     endcase
                  end

                  // push with overflow check
                  if (push_req) begin
                     if (full) begin
                        res_vld    = 1'b1;
                        res_status = bcqc_pkg::ST_OVERFLOW;
                        res_kind   = op_kind;
                        halted_in  = 1'b1;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end

                  // pop with kind match
                  if (pop_req) begin
                     if (!have_top || top_kind != op_kind) begin
                        res_vld    = 1'b1;
                        res_status = bcqc_pkg::ST_UNEXP;
                        res_kind   = op_kind;
                        halted_in  = 1'b1;
                     end else begin
                        cmd.pop = 1'b1;
                     end
                  end
               end

               if (col_ff != '1) begin
                  col_in = col_ff + COL_BITS'(1);
               end
               prev_ch_in  = c;
               prev_vld_in = 1'b1;
               bs_par_in   = (c == bcqc_pkg::CH_BSLASH) ? !bs_par_ff : 1'b0;
            end
            bcqc_pkg::REQ_EOL: begin
               if (row_ff != '1) begin
                  row_in = row_ff + ROW_BITS'(1);
               end
               col_in      = '0;
               prev_ch_in  = '0;
               prev_vld_in = 1'b0;
               bs_par_in   = 1'b0;
               line_cmt_in = 1'b0;
            end
            bcqc_pkg::REQ_EOT: begin
               if (!halted_ff) begin
                  res_vld = 1'b1;
                  if (have_top) begin
                     res_status = bcqc_pkg::ST_UNCLOSED;
                     res_kind   = top_kind;
                     res_row    = top_row;
                     res_col    = top_col;
                  end else begin
                     res_status = bcqc_pkg::ST_BALANCED;
                     res_kind   = bcqc_pkg::K_ROUND;
                     res_row    = '0;
                     res_col    = '0;
                  end
               end
               cmd.clear   = 1'b1;
               row_in      = '0;
               col_in      = '0;
               prev_ch_in  = '0;
               prev_vld_in = 1'b0;
               bs_par_in   = 1'b0;
               line_cmt_in = 1'b0;
               halted_in   = 1'b0;
            end
            default: ;
         endcase
      end
   end

   // entry word of the symbol being pushed
   assign push_entry = {op_kind, row_ff, col_ff};

   // saturate or zero-extend reported positions to the report field widths
   if (ROW_BITS > bcqc_pkg::ROW_OUT_W) begin : g_row_sat
      assign sat_row = (|res_row[ROW_BITS-1:bcqc_pkg::ROW_OUT_W]) ? '1 :
                       res_row[bcqc_pkg::ROW_OUT_W-1:0];
   end else begin : g_row_ext
      assign sat_row = bcqc_pkg::row_out_type'(res_row);
   end

   if (COL_BITS > bcqc_pkg::COL_OUT_W) begin : g_col_sat
      assign sat_col = (|res_col[COL_BITS-1:bcqc_pkg::COL_OUT_W]) ? '1 :
                       res_col[bcqc_pkg::COL_OUT_W-1:0];
   end else begin : g_col_ext
      assign sat_col = bcqc_pkg::col_out_type'(res_col);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         prev_ch_ff  <= '0;
         prev_vld_ff <= 1'b0;
         bs_par_ff   <= 1'b0;
         line_cmt_ff <= 1'b0;
         halted_ff   <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         prev_ch_ff  <= prev_ch_in;
         prev_vld_ff <= prev_vld_in;
         bs_par_ff   <= bs_par_in;
         line_cmt_ff <= line_cmt_in;
         halted_ff   <= halted_in;
      end
   end

   // report register, held until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (res_vld) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (res_vld) begin
         rsp_status_ff <= res_status;
         rsp_kind_ff   <= res_kind;
         rsp_row_ff    <= sat_row;
         rsp_col_ff    <= sat_col;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.symbol_kind   = rsp_kind_ff;
   assign rsp_chan.row_number    = rsp_row_ff;
   assign rsp_chan.column_number = rsp_col_ff;

   bcqc_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .ENTRY_W     (ENTRY_W)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .push_entry (push_entry),
      .top_entry  (top_entry),
      .depth      (depth)
   );

endmodule

`default_nettype wire

// ===== sv/bcqc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcqc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_type,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic [2:0] rsp_kind,
   input wire logic [15:0] rsp_row,
   input wire logic [11:0] rsp_col
);

   // a fresh report only follows a character or end-of-text word
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready &&
                                 (req_type == bcqc_pkg::REQ_CHAR ||
                                  req_type == bcqc_pkg::REQ_EOT)))
      else $error("report without a causing request");

   // end of line never yields a report
   a_eol_silent : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == bcqc_pkg::REQ_EOL && !rsp_valid) |=>
         !rsp_valid)
      else $error("report after end of line");

   // balanced report carries no kind or position
   a_balanced_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bcqc_pkg::ST_BALANCED) |->
         (rsp_kind == bcqc_pkg::K_ROUND && rsp_row == 16'd0 && rsp_col == 12'd0))
      else $error("balanced report with non-zero fields");

   // no back-pressure while the report register is empty
   a_ready_free : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty report register");

   // a held report stays until taken
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("report dropped while stalled");

endmodule

bind bracket_comment_quote_checker_top bcqc_checker u_bcqc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_type   (req_chan.req_type),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_kind   (rsp_chan.symbol_kind),
   .rsp_row    (rsp_chan.row_number),
   .rsp_col    (rsp_chan.column_number)
);

`default_nettype wire
